### sv/tss_pkg.sv
// Package for the telemetry signal store: command codes, controller states,
// the control and status structs between controller and datapath. No dependencies.
package tss_pkg;

    typedef enum logic [2:0] {
        CMD_UPDATE     = 3'd0,
        CMD_INVALIDATE = 3'd1,
        CMD_READ       = 3'd2,
        CMD_SNAPSHOT   = 3'd3,
        CMD_STATS      = 3'd4,
        CMD_DEFINE     = 3'd5
    } cmd_t;

    // Event counter numbers.
    localparam logic [2:0] EV_ACCEPT  = 3'd0;
    localparam logic [2:0] EV_BAD_ID  = 3'd1;
    localparam logic [2:0] EV_BAD_SRC = 3'd2;
    localparam logic [2:0] EV_BAD_TYP = 3'd3;
    localparam logic [2:0] EV_BAD_RNG = 3'd4;
    localparam logic [2:0] EV_BAD_TIM = 3'd5;
    localparam logic [2:0] EV_INVAL   = 3'd6;
    localparam logic [2:0] EV_STALE   = 3'd7;

    localparam logic [1:0] Q_INVALID = 2'd0;
    localparam logic [1:0] Q_VALID   = 2'd1;
    localparam logic [1:0] Q_STALE   = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_EXEC,
        ST_EMIT,
        ST_LIST,
        ST_STATS
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic       load;       // capture the command beat
        logic       sweep;      // stale check of entry at index
        logic       exec;       // execute update/invalidate/define on the latched entry
        logic       emit;       // drive one result
        logic       emit_ctr;   // result carries an event counter
        logic       emit_err;   // result carries status 1 with zeroed fields
        logic       emit_last;
        logic [5:0] index;      // sweep/list/counter index
        logic       use_index;  // result reports index instead of latched id
    } tss_ctrl_t;

    // Datapath to controller.
    typedef struct packed {
        cmd_t       cmd;
        logic       bad_cmd;
        logic       id_ok;
    } tss_stat_t;

endpackage

### sv/tss_datapath.sv
// Datapath of the telemetry signal store: signal and catalog tables, checks,
// event counters and the result register. Depends on tss_pkg.
module tss_datapath
    import tss_pkg::*;
#(
    parameter int SIGNAL_COUNT = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  tss_ctrl_t          ctrl,
    output tss_stat_t          stat,
    input  logic [2:0]         cmd,
    input  logic [7:0]         signal_id,
    input  logic [7:0]         producer,
    input  logic [1:0]         signal_type,
    input  logic signed [63:0] sample_value,
    input  logic [31:0]        time_ms,
    input  logic signed [63:0] lower_limit,
    input  logic signed [63:0] upper_limit,
    input  logic [31:0]        stale_timeout,
    output logic               strobe,
    output logic               status,
    output logic [5:0]         entry_index,
    output logic [1:0]         quality,
    output logic signed [63:0] stored_value,
    output logic [31:0]        stored_time,
    output logic [31:0]        update_count,
    output logic               time_known,
    output logic [31:0]        sequence_res,
    output logic               last
);

    localparam int IW = (SIGNAL_COUNT > 1) ? $clog2(SIGNAL_COUNT) : 1;

    // Tables are flip-flops so that reset clears them at once.
    logic [7:0]         src_reg  [SIGNAL_COUNT];
    logic [1:0]         kind_reg [SIGNAL_COUNT];
    logic signed [63:0] lo_reg   [SIGNAL_COUNT];
    logic signed [63:0] hi_reg   [SIGNAL_COUNT];
    logic [31:0]        tmo_reg  [SIGNAL_COUNT];
    logic signed [63:0] val_reg  [SIGNAL_COUNT];
    logic [31:0]        tim_reg  [SIGNAL_COUNT];
    logic [31:0]        cnt_reg  [SIGNAL_COUNT];
    logic [1:0]         qual_reg [SIGNAL_COUNT];
    logic               stmp_reg [SIGNAL_COUNT];
    logic [31:0]        ev_reg   [8];
    logic [31:0]        seq_reg;

    // Latched command beat.
    logic [2:0]         cmd_reg;
    logic [7:0]         id_reg;
    logic [7:0]         prod_reg;
    logic [1:0]         type_reg;
    logic signed [63:0] smp_reg;
    logic [31:0]        t_reg;
    logic signed [63:0] lol_reg;
    logic signed [63:0] upl_reg;
    logic [31:0]        tmol_reg;

    logic          id_ok;
    logic [IW-1:0] id_ix;
    logic [IW-1:0] sw_ix;
    logic [IW-1:0] rd_ix;
    logic          sw_hit;
    logic          fit;
    logic [31:0]   tdiff;
    logic          early;
    logic [2:0]    fail_ev;
    logic          fail;

    assign id_ok = ({24'd0, id_reg} < 32'(SIGNAL_COUNT));
    assign id_ix = id_reg[IW-1:0];
    assign sw_ix = ctrl.index[IW-1:0];
    assign rd_ix = ctrl.use_index ? sw_ix : id_ix;

    assign stat.cmd     = cmd_t'(cmd_reg);
    assign stat.bad_cmd = (cmd_reg > CMD_DEFINE);
    assign stat.id_ok   = id_ok;

    assign sw_hit = (qual_reg[sw_ix] == Q_VALID)
                  && ((t_reg - tim_reg[sw_ix]) > tmo_reg[sw_ix]);

    always_comb
    begin
        case (type_reg)
            2'd0:    fit = (smp_reg >= -64'sd2147483648) && (smp_reg <= 64'sd2147483647);
            2'd1:    fit = (smp_reg[63:32] == 32'd0);
            2'd2:    fit = (smp_reg == 64'sd0) || (smp_reg == 64'sd1);
            default: fit = 1'b0;
        endcase
    end

    assign tdiff = t_reg - tim_reg[id_ix];
    assign early = stmp_reg[id_ix] && tdiff[31];

    always_comb
    begin
        fail_ev = EV_ACCEPT;
        if (prod_reg != src_reg[id_ix])
            fail_ev = EV_BAD_SRC;
        else if (cmd_reg == CMD_UPDATE && (type_reg != kind_reg[id_ix] || !fit))
            fail_ev = EV_BAD_TYP;
        else if (cmd_reg == CMD_UPDATE
                 && (smp_reg < lo_reg[id_ix] || hi_reg[id_ix] < smp_reg))
            fail_ev = EV_BAD_RNG;
        else if (early)
            fail_ev = EV_BAD_TIM;
    end
    assign fail = (fail_ev != EV_ACCEPT);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg  <= cmd;
            id_reg   <= signal_id;
            prod_reg <= producer;
            type_reg <= signal_type;
            smp_reg  <= sample_value;
            t_reg    <= time_ms;
            lol_reg  <= lower_limit;
            upl_reg  <= upper_limit;
            tmol_reg <= stale_timeout;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SIGNAL_COUNT; i++)
            begin
                src_reg[i]  <= '0;
                kind_reg[i] <= '0;
                lo_reg[i]   <= '0;
                hi_reg[i]   <= '0;
                tmo_reg[i]  <= '0;
                val_reg[i]  <= '0;
                tim_reg[i]  <= '0;
                cnt_reg[i]  <= '0;
                qual_reg[i] <= Q_INVALID;
                stmp_reg[i] <= 1'b0;
            end
            for (int k = 0; k < 8; k++)
                ev_reg[k] <= '0;
            seq_reg <= '0;
        end
        else if (ctrl.sweep)
        begin
            if (sw_hit)
            begin
                qual_reg[sw_ix]  <= Q_STALE;
                ev_reg[EV_STALE] <= ev_reg[EV_STALE] + 32'd1;
                seq_reg          <= seq_reg + 32'd1;
            end
        end
        else if (ctrl.exec)
        begin
            if (!id_ok)
            begin
                if (cmd_reg == CMD_UPDATE || cmd_reg == CMD_INVALIDATE)
                    ev_reg[EV_BAD_ID] <= ev_reg[EV_BAD_ID] + 32'd1;
            end
            else if (cmd_reg == CMD_DEFINE)
            begin
                src_reg[id_ix]  <= prod_reg;
                kind_reg[id_ix] <= type_reg;
                lo_reg[id_ix]   <= lol_reg;
                hi_reg[id_ix]   <= upl_reg;
                tmo_reg[id_ix]  <= tmol_reg;
            end
            else if (cmd_reg == CMD_UPDATE || cmd_reg == CMD_INVALIDATE)
            begin
                if (fail)
                    ev_reg[fail_ev] <= ev_reg[fail_ev] + 32'd1;
                else
                begin
                    tim_reg[id_ix]  <= t_reg;
                    stmp_reg[id_ix] <= 1'b1;
                    seq_reg         <= seq_reg + 32'd1;
                    if (cmd_reg == CMD_UPDATE)
                    begin
                        val_reg[id_ix]   <= smp_reg;
                        cnt_reg[id_ix]   <= cnt_reg[id_ix] + 32'd1;
                        qual_reg[id_ix]  <= Q_VALID;
                        ev_reg[EV_ACCEPT] <= ev_reg[EV_ACCEPT] + 32'd1;
                    end
                    else
                    begin
                        qual_reg[id_ix] <= Q_INVALID;
                        ev_reg[EV_INVAL] <= ev_reg[EV_INVAL] + 32'd1;
                    end
                end
            end
        end
    end

    // Status of the executed command is kept for its result beat.
    logic fail_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fail_reg <= 1'b0;
        else if (ctrl.load)
            fail_reg <= 1'b0;
        else if (ctrl.exec)
            fail_reg <= id_ok && (cmd_reg == CMD_UPDATE || cmd_reg == CMD_INVALIDATE)
                        && fail;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe <= 1'b0;
        else
            strobe <= ctrl.emit;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            sequence_res <= seq_reg;
            last         <= ctrl.emit_last;
            if (ctrl.emit_err)
            begin
                status       <= 1'b1;
                entry_index  <= '0;
                quality      <= '0;
                stored_value <= '0;
                stored_time  <= '0;
                update_count <= '0;
                time_known   <= 1'b0;
            end
            else if (ctrl.emit_ctr)
            begin
                status       <= 1'b0;
                entry_index  <= ctrl.index;
                quality      <= '0;
                stored_value <= {32'd0, ev_reg[ctrl.index[2:0]]};
                stored_time  <= '0;
                update_count <= '0;
                time_known   <= 1'b0;
            end
            else
            begin
                status       <= ctrl.use_index ? 1'b0 : fail_reg;
                entry_index  <= 6'(rd_ix);
                quality      <= qual_reg[rd_ix];
                stored_value <= val_reg[rd_ix];
                stored_time  <= tim_reg[rd_ix];
                update_count <= cnt_reg[rd_ix];
                time_known   <= stmp_reg[rd_ix];
            end
        end
    end

endmodule

### sv/tss_control.sv
// Controller of the telemetry signal store: sequences sweeps, execution and
// result beats. Depends on tss_pkg.
module tss_control
    import tss_pkg::*;
#(
    parameter int SIGNAL_COUNT = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  tss_stat_t stat,
    output tss_ctrl_t ctrl
);

    localparam logic [5:0] LAST_IX = 6'(SIGNAL_COUNT - 1);

    state_t     state_reg, state_next;
    logic [5:0] ix_reg, ix_next;
    logic       accept;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ix_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ix_reg    <= ix_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ix_next    = ix_reg;
        unique case (state_reg)
            ST_IDLE:
                if (start)
                    state_next = ST_EXEC;
            ST_EXEC:
            begin
                ix_next = '0;
                if (stat.bad_cmd)
                    state_next = ST_EMIT;
                else if (stat.cmd == CMD_SNAPSHOT
                         || (stat.cmd == CMD_READ && stat.id_ok))
                    state_next = ST_SWEEP;
                else if (stat.cmd == CMD_STATS)
                    state_next = ST_STATS;
                else
                    state_next = ST_EMIT;
            end
            ST_SWEEP:
            begin
                ix_next = ix_reg + 6'd1;
                if (ix_reg == LAST_IX)
                begin
                    ix_next    = '0;
                    state_next = (stat.cmd == CMD_SNAPSHOT) ? ST_LIST : ST_EMIT;
                end
            end
            ST_LIST:
            begin
                ix_next = ix_reg + 6'd1;
                if (ix_reg == LAST_IX)
                    state_next = ST_IDLE;
            end
            ST_STATS:
            begin
                ix_next = ix_reg + 6'd1;
                if (ix_reg == 6'd7)
                    state_next = ST_IDLE;
            end
            ST_EMIT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        ctrl.index = ix_reg;
        unique case (state_reg)
            ST_IDLE:
                ctrl.load = accept;
            ST_EXEC:
                ctrl.exec = !stat.bad_cmd;
            ST_SWEEP:
                ctrl.sweep = 1'b1;
            ST_LIST:
            begin
                ctrl.emit      = 1'b1;
                ctrl.use_index = 1'b1;
                ctrl.emit_last = (ix_reg == LAST_IX);
            end
            ST_STATS:
            begin
                ctrl.emit      = 1'b1;
                ctrl.emit_ctr  = 1'b1;
                ctrl.emit_last = (ix_reg == 6'd7);
            end
            ST_EMIT:
            begin
                ctrl.emit      = 1'b1;
                ctrl.emit_last = 1'b1;
                ctrl.emit_err  = stat.bad_cmd || !stat.id_ok;
            end
            default: ;
        endcase
    end

endmodule

### sv/telemetry_signal_store_unit.sv
// Top level of the telemetry signal store: controller plus datapath.
// Depends on tss_pkg, tss_control and tss_datapath.
//
//  channel  | handshake                   | beat
//  command  | start high while busy low   | cmd, signal_id, ... stale_timeout
//  result   | strobe high for one cycle   | status ... sequence_res, last
//
// Update, invalidate, define and bad commands go from the execute state to the emit state.
// Read of an id in range and snapshot first run the stale sweep, which checks one table
// entry per cycle; snapshot then lists every entry. Statistics lists the eight counters.
// Reset clears all tables at once. The receiver cannot stall results.
module telemetry_signal_store_unit
    import tss_pkg::*;
#(
    parameter int SIGNAL_COUNT = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         cmd,
    input  logic [7:0]         signal_id,
    input  logic [7:0]         producer,
    input  logic [1:0]         signal_type,
    input  logic signed [63:0] sample_value,
    input  logic [31:0]        time_ms,
    input  logic signed [63:0] lower_limit,
    input  logic signed [63:0] upper_limit,
    input  logic [31:0]        stale_timeout,
    output logic               strobe,
    output logic               status,
    output logic [5:0]         entry_index,
    output logic [1:0]         quality,
    output logic signed [63:0] stored_value,
    output logic [31:0]        stored_time,
    output logic [31:0]        update_count,
    output logic               time_known,
    output logic [31:0]        sequence_res,
    output logic               last
);

    tss_ctrl_t ctrl;
    tss_stat_t stat;

    tss_control #(.SIGNAL_COUNT(SIGNAL_COUNT)) u_control (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    tss_datapath #(.SIGNAL_COUNT(SIGNAL_COUNT)) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .cmd           (cmd),
        .signal_id     (signal_id),
        .producer      (producer),
        .signal_type   (signal_type),
        .sample_value  (sample_value),
        .time_ms       (time_ms),
        .lower_limit   (lower_limit),
        .upper_limit   (upper_limit),
        .stale_timeout (stale_timeout),
        .strobe        (strobe),
        .status        (status),
        .entry_index   (entry_index),
        .quality       (quality),
        .stored_value  (stored_value),
        .stored_time   (stored_time),
        .update_count  (update_count),
        .time_known    (time_known),
        .sequence_res  (sequence_res),
        .last          (last)
    );

endmodule

### sv/tss_checker.sv
// Port checker for the telemetry signal store, bound to the top level.
// Depends on telemetry_signal_store_unit.
module tss_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       strobe,
    input logic       last,
    input logic [1:0] quality
);

    // An accepted command always makes the block busy.
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("start accepted without busy");

    // The final beat of a command frees the block.
    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> !busy)
        else $error("busy after final beat");

    // No result beat appears while idle unless it is the final one.
    a_beat_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("non-final beat while idle");

    // Quality never shows the unused code.
    a_quality: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> quality != 2'd3)
        else $error("bad quality code");

endmodule

bind telemetry_signal_store_unit tss_checker u_tss_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .strobe  (strobe),
    .last    (last),
    .quality (quality)
);

### bench/telemetry_signal_store_unit_tb.sv
// Self-checking testbench for telemetry_signal_store_unit: a directed table,
// then random command beats, all results checked against a built-in predictor.
// Depends on tss_pkg and the telemetry_signal_store_unit RTL.
`timescale 1ns / 100ps

module telemetry_signal_store_unit_tb;
    import tss_pkg::*;

    localparam int NSIG = 32;
    localparam logic [2:0] CMD_BAD6 = 3'd6;
    localparam logic [2:0] CMD_BAD7 = 3'd7;
    localparam logic [1:0] KIND_S32 = 2'd0;
    localparam logic [1:0] KIND_U32 = 2'd1;
    localparam logic [1:0] KIND_BOOL = 2'd2;
    localparam logic [1:0] KIND_OTHER = 2'd3;
    localparam logic signed [63:0] S64_MIN = 64'sh8000000000000000;
    localparam logic signed [63:0] S64_MAX = 64'sh7FFFFFFFFFFFFFFF;

    typedef struct {
        logic [2:0]         op;
        logic [7:0]         id;
        logic [7:0]         src;
        logic [1:0]         kind;
        logic signed [63:0] val;
        logic [31:0]        tms;
        logic signed [63:0] lo;
        logic signed [63:0] hi;
        logic [31:0]        tmo;
        int                 want_status;   // -1 when the predictor alone decides
    } beat_t;

    typedef struct packed {
        logic        status;
        logic [5:0]  idx;
        logic [1:0]  qual;
        logic [63:0] value;
        logic [31:0] stime;
        logic [31:0] count;
        logic        known;
        logic [31:0] seq;
        logic        last;
    } entry_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    logic busy;
    logic [2:0] cmd;
    logic [7:0] signal_id;
    logic [7:0] producer;
    logic [1:0] signal_type;
    logic signed [63:0] sample_value;
    logic [31:0] time_ms;
    logic signed [63:0] lower_limit;
    logic signed [63:0] upper_limit;
    logic [31:0] stale_timeout;
    logic strobe;
    logic status;
    logic [5:0] entry_index;
    logic [1:0] quality;
    logic signed [63:0] stored_value;
    logic [31:0] stored_time;
    logic [31:0] update_count;
    logic time_known;
    logic [31:0] sequence_res;
    logic last;

    telemetry_signal_store_unit #(.SIGNAL_COUNT(NSIG)) uut (.*);

    always #1 clk = ~clk;

    initial
    begin
        #2000000;
        $display("FAIL telemetry_signal_store_unit");
        $finish;
    end

    // Predictor state.
    logic [7:0]         cat_src [NSIG];
    logic [1:0]         cat_kind [NSIG];
    logic signed [63:0] cat_lo [NSIG];
    logic signed [63:0] cat_hi [NSIG];
    logic [31:0]        cat_tmo [NSIG];
    logic [63:0]        sig_val [NSIG];
    logic [31:0]        sig_time [NSIG];
    logic [31:0]        sig_cnt [NSIG];
    logic [1:0]         sig_qual [NSIG];
    logic               sig_known [NSIG];
    logic [31:0]        ev_count [8];
    logic [31:0]        chg_seq;

    entry_result_t pending[$];
    int errors = 0;
    int checked = 0;
    int beats = 0;
    int snapshots = 0;

    function automatic bit kind_fits(logic [1:0] k, logic [63:0] v);
        case (k)
            KIND_S32:  return (v + 64'h80000000) < 64'h100000000;
            KIND_U32:  return v < 64'h100000000;
            KIND_BOOL: return v == 64'd0 || v == 64'd1;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit older_than(logic [31:0] cand, logic [31:0] ref_t);
        logic [31:0] d;
        d = cand - ref_t;
        return d[31];
    endfunction

    function automatic void mark_stale(logic [31:0] now);
        for (int i = 0; i < NSIG; i++)
        begin
            if (sig_qual[i] == Q_VALID && (now - sig_time[i]) > cat_tmo[i])
            begin
                sig_qual[i] = Q_STALE;
                ev_count[EV_STALE]++;
                chg_seq++;
            end
        end
    endfunction

    function automatic void push_entry(logic st, int i, logic lst);
        entry_result_t r;
        r = '{st, i[5:0], sig_qual[i], sig_val[i], sig_time[i], sig_cnt[i],
              sig_known[i], chg_seq, lst};
        pending.push_back(r);
    endfunction

    function automatic void push_error();
        entry_result_t r;
        r = '0;
        r.status = 1'b1;
        r.seq = chg_seq;
        r.last = 1'b1;
        pending.push_back(r);
    endfunction

    function automatic void predict_store(beat_t b);
        int id;
        logic [2:0] why;
        entry_result_t r;
        id = b.id;
        why = '0;
        if (b.op == CMD_SNAPSHOT)
        begin
            mark_stale(b.tms);
            for (int i = 0; i < NSIG; i++)
                push_entry(1'b0, i, i == NSIG - 1);
        end
        else if (b.op == CMD_STATS)
        begin
            for (int k = 0; k < 8; k++)
            begin
                r = '0;
                r.idx = k[5:0];
                r.value = {32'd0, ev_count[k]};
                r.seq = chg_seq;
                r.last = (k == 7);
                pending.push_back(r);
            end
        end
        else if (b.op == CMD_BAD6 || b.op == CMD_BAD7)
            push_error();
        else if (id >= NSIG)
        begin
            if (b.op == CMD_UPDATE || b.op == CMD_INVALIDATE)
                ev_count[EV_BAD_ID]++;
            push_error();
        end
        else if (b.op == CMD_UPDATE)
        begin
            if (b.src != cat_src[id])
                why = EV_BAD_SRC;
            else if (b.kind != cat_kind[id] || !kind_fits(b.kind, b.val))
                why = EV_BAD_TYP;
            else if (b.val < cat_lo[id] || cat_hi[id] < b.val)
                why = EV_BAD_RNG;
            else if (sig_known[id] && older_than(b.tms, sig_time[id]))
                why = EV_BAD_TIM;
            if (why != 0)
                ev_count[why]++;
            else
            begin
                sig_val[id] = b.val;
                sig_time[id] = b.tms;
                sig_cnt[id]++;
                sig_qual[id] = Q_VALID;
                sig_known[id] = 1'b1;
                ev_count[EV_ACCEPT]++;
                chg_seq++;
            end
            push_entry(why != 0, id, 1'b1);
        end
        else if (b.op == CMD_INVALIDATE)
        begin
            if (b.src != cat_src[id])
                why = EV_BAD_SRC;
            else if (sig_known[id] && older_than(b.tms, sig_time[id]))
                why = EV_BAD_TIM;
            if (why != 0)
                ev_count[why]++;
            else
            begin
                sig_time[id] = b.tms;
                sig_qual[id] = Q_INVALID;
                sig_known[id] = 1'b1;
                ev_count[EV_INVAL]++;
                chg_seq++;
            end
            push_entry(why != 0, id, 1'b1);
        end
        else if (b.op == CMD_READ)
        begin
            mark_stale(b.tms);
            push_entry(1'b0, id, 1'b1);
        end
        else
        begin
            cat_src[id] = b.src;
            cat_kind[id] = b.kind;
            cat_lo[id] = b.lo;
            cat_hi[id] = b.hi;
            cat_tmo[id] = b.tmo;
            push_entry(1'b0, id, 1'b1);
        end
    endfunction

    // Result checker; outputs are sampled at the edge that ends the strobe cycle.
    always @(posedge clk)
    begin
        entry_result_t got;
        entry_result_t want;
        if (rst_n && strobe)
        begin
            got = '{status, entry_index, quality, stored_value, stored_time,
                    update_count, time_known, sequence_res, last};
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result beat: %p", got);
            end
            else
            begin
                want = pending.pop_front();
                checked++;
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch at %0t\n  expected %p\n  actual   %p",
                                 $realtime, want, got);
                end
            end
        end
    end

    task automatic send(beat_t b, bit may_idle);
        int before_cnt;
        cmd <= b.op;
        signal_id <= b.id;
        producer <= b.src;
        signal_type <= b.kind;
        sample_value <= b.val;
        time_ms <= b.tms;
        lower_limit <= b.lo;
        upper_limit <= b.hi;
        stale_timeout <= b.tmo;
        start <= 1'b1;
        do @(posedge clk); while (busy);
        before_cnt = pending.size();
        predict_store(b);
        if (b.want_status >= 0)
            pending[before_cnt].status = b.want_status[0];
        beats++;
        if (b.op == CMD_SNAPSHOT)
            snapshots++;
        if (may_idle && $urandom_range(0, 99) < 30)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
    endtask

    function automatic beat_t mk(logic [2:0] op, logic [7:0] id, logic [7:0] src,
                                 logic [1:0] kind, logic signed [63:0] val,
                                 logic [31:0] tms, logic signed [63:0] lo,
                                 logic signed [63:0] hi, logic [31:0] tmo,
                                 int want_status);
        beat_t b;
        b = '{op, id, src, kind, val, tms, lo, hi, tmo, want_status};
        return b;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly well-formed beats for entries in range; the rest is noise.
    function automatic beat_t random_beat(ref logic [31:0] clock_ms);
        beat_t b;
        int pick;
        int id;
        b = mk(CMD_UPDATE, 8'd0, 8'd0, KIND_S32, 0, 0, 0, 0, 0, -1);
        pick = $urandom_range(0, 99);
        id = $urandom_range(0, NSIG - 1);
        clock_ms += $urandom_range(0, 60);
        if ($urandom_range(0, 19) == 0)
            clock_ms -= $urandom_range(1, 200);  // late stamp
        b.id = id;
        b.src = cat_src[id];
        b.kind = cat_kind[id];
        b.tms = clock_ms;
        if (pick < 50)
        begin
            b.op = CMD_UPDATE;
            case (b.kind)
                KIND_S32:  b.val = $signed($urandom_range(0, 2000)) - 400;
                KIND_U32:  b.val = $urandom_range(0, 3000);
                KIND_BOOL: b.val = $urandom_range(0, 1);
                default:   b.val = rand64();
            endcase
            if ($urandom_range(0, 9) == 0)
                b.src = $urandom;
            if ($urandom_range(0, 9) == 0)
                b.val = rand64();
        end
        else if (pick < 60)
            b.op = CMD_INVALIDATE;
        else if (pick < 70)
            b.op = CMD_READ;
        else if (pick < 74)
            b.op = CMD_SNAPSHOT;
        else if (pick < 77)
            b.op = CMD_STATS;
        else if (pick < 88)
        begin
            b.op = CMD_DEFINE;
            b.src = $urandom;
            b.kind = $urandom_range(0, 3);
            b.lo = -$signed({1'b0, 31'($urandom_range(0, 600))});
            b.hi = $urandom_range(0, 2500);
            if ($urandom_range(0, 7) == 0)
            begin
                b.lo = rand64();
                b.hi = rand64();
            end
            b.tmo = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 400);
        end
        else
        begin
            b = mk($urandom_range(0, 7), $urandom, $urandom, $urandom_range(0, 3),
                   rand64(), $urandom, rand64(), rand64(), $urandom, -1);
            if (b.op == CMD_DEFINE && b.id < NSIG)
                b.op = CMD_READ;
        end
        return b;
    endfunction

    initial
    begin
        beat_t table_rows[$];
        logic [31:0] clock_ms;
        for (int i = 0; i < NSIG; i++)
        begin
            cat_src[i] = '0; cat_kind[i] = '0; cat_lo[i] = '0; cat_hi[i] = '0;
            cat_tmo[i] = '0; sig_val[i] = '0; sig_time[i] = '0; sig_cnt[i] = '0;
            sig_qual[i] = Q_INVALID; sig_known[i] = 1'b0;
        end
        for (int k = 0; k < 8; k++)
            ev_count[k] = '0;
        chg_seq = '0;

        rst_n <= 1'b0;
        start <= 1'b0;
        cmd <= CMD_READ;
        signal_id <= '0;
        producer <= '0;
        signal_type <= '0;
        sample_value <= '0;
        time_ms <= '0;
        lower_limit <= '0;
        upper_limit <= '0;
        stale_timeout <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        table_rows.push_back(mk(CMD_STATS, 0, 0, KIND_S32, 0, 0, 0, 0, 0, 0));
        table_rows.push_back(mk(CMD_READ, 0, 0, KIND_S32, 0, 0, 0, 0, 0, 0));
        table_rows.push_back(mk(CMD_UPDATE, 0, 0, KIND_S32, 0, 0, 0, 0, 0, 0));
        table_rows.push_back(mk(CMD_UPDATE, 40, 0, KIND_S32, 0, 0, 0, 0, 0, 1));
        table_rows.push_back(mk(CMD_INVALIDATE, 255, 0, KIND_S32, 0, 0, 0, 0, 0, 1));
        table_rows.push_back(mk(CMD_READ, 32, 0, KIND_S32, 0, 0, 0, 0, 0, 1));
        table_rows.push_back(mk(CMD_DEFINE, 255, 1, KIND_S32, 0, 0, 0, 0, 0, 1));
        table_rows.push_back(mk(CMD_DEFINE, 31, 255, KIND_U32, 0, 0, 0,
                                64'hFFFFFFFF, 32'hFFFFFFFF, 0));
        table_rows.push_back(mk(CMD_UPDATE, 31, 255, KIND_U32, 64'hFFFFFFFF,
                                32'hFFFFFFFF, 0, 0, 0, 0));
        table_rows.push_back(mk(CMD_UPDATE, 31, 254, KIND_U32, 5, 32'hFFFFFFFF,
                                0, 0, 0, 1));
        table_rows.push_back(mk(CMD_UPDATE, 31, 255, KIND_S32, 5, 32'hFFFFFFFF,
                                0, 0, 0, 1));
        table_rows.push_back(mk(CMD_UPDATE, 31, 255, KIND_OTHER, S64_MAX,
                                32'hFFFFFFFF, 0, 0, 0, 1));
        table_rows.push_back(mk(CMD_UPDATE, 31, 255, KIND_U32, 64'h100000000,
                                32'hFFFFFFFF, 0, 0, 0, 1));
        table_rows.push_back(mk(CMD_UPDATE, 31, 255, KIND_U32, 7, 32'hFFFFFFF0,
                                0, 0, 0, 1));
        table_rows.push_back(mk(CMD_DEFINE, 1, 8'h5A, KIND_S32, 0, 0, S64_MIN,
                                S64_MAX, 0, 0));
        table_rows.push_back(mk(CMD_UPDATE, 1, 8'h5A, KIND_S32, 64'sh7FFFFFFF, 100,
                                0, 0, 0, 0));
        table_rows.push_back(mk(CMD_UPDATE, 1, 8'h5A, KIND_S32, -64'sh80000000, 100,
                                0, 0, 0, 0));
        table_rows.push_back(mk(CMD_UPDATE, 1, 8'h5A, KIND_S32, 64'sh80000000, 101,
                                0, 0, 0, 1));
        table_rows.push_back(mk(CMD_DEFINE, 2, 8'hA5, KIND_BOOL, 0, 0, 5, 0,
                                32'd10, 0));
        table_rows.push_back(mk(CMD_UPDATE, 2, 8'hA5, KIND_BOOL, 1, 0, 0, 0, 0, 1));
        table_rows.push_back(mk(CMD_INVALIDATE, 31, 255, KIND_S32, 0, 32'hFFFFFFFF,
                                0, 0, 0, 0));
        table_rows.push_back(mk(CMD_READ, 1, 0, KIND_S32, 0, 32'h80000000, 0, 0, 0, 0));
        table_rows.push_back(mk(CMD_SNAPSHOT, 0, 0, KIND_S32, 0, 32'h80000000, 0, 0,
                                0, 0));
        table_rows.push_back(mk(CMD_BAD6, 0, 0, KIND_S32, 0, 0, 0, 0, 0, 1));
        table_rows.push_back(mk(CMD_BAD7, 0, 0, KIND_S32, 0, 0, 0, 0, 0, 1));
        foreach (table_rows[i])
            send(table_rows[i], 1'b1);
        drain();

        clock_ms = 32'hFFFFFF00;   // lets the random clock wrap early
        for (int n = 0; n < 380; n++)
        begin
            if (n == 190)
                drain();
            send(random_beat(clock_ms), !(n >= 100 && n < 200));
        end
        send(mk(CMD_STATS, 0, 0, KIND_S32, 0, 0, 0, 0, 0, -1), 1'b0);
        start <= 1'b0;

        for (int w = 0; w < 5000 && pending.size() != 0; w++)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (pending.size() != 0)
        begin
            errors++;
            $display("%0d expected result beats never arrived", pending.size());
        end
        $display("Run covered %0d command beats (%0d snapshots) and %0d result beats;",
                 beats, snapshots, checked);
        $display("%0d mismatches in total.", errors);
        if (errors == 0)
            $display("PASS telemetry_signal_store_unit");
        else
            $display("FAIL telemetry_signal_store_unit");
        $finish;
    end

endmodule

### sim.f
sv/tss_pkg.sv
sv/tss_datapath.sv
sv/tss_control.sv
sv/telemetry_signal_store_unit.sv
sv/tss_checker.sv
bench/telemetry_signal_store_unit_tb.sv
